[hw/rtl/spbs_pkg.sv]
// Shared types, operation codes and constant-divide helpers for the split pixel unit.
package spbs_pkg;

    localparam int unsigned PIXEL_W = 16;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned LEVEL_W = 5;
    localparam int unsigned STEP_W  = 2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MOD   = 2'd1,
        OP_LIGHT = 2'd2,
        OP_BLEND = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  req_type;
        logic [PIXEL_W-1:0]   pixel_in;
        logic [COLOR_W-1:0]   first_color;
        logic [COLOR_W-1:0]   second_color;
        logic [LEVEL_W-1:0]   light_level;
        logic [STEP_W-1:0]    alpha_step;
    } req_t;

    // Floor divide by 7 for values below 512: x * 293 / 2048.
    function automatic logic [6:0] div7(input logic [8:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd293;
        return prod[17:11];
    endfunction

    // Floor divide by 3 for values up to 9: x * 11 / 32.
    function automatic logic [1:0] div3(input logic [3:0] x);
        logic [7:0] prod;
        prod = 8'(x) * 8'd11;
        return prod[6:5];
    endfunction

endpackage

[hw/rtl/spbs_calc.sv]
// Combinational pixel datapath: add, modulate, light and blend on one item.
module spbs_calc (
    input  spbs_pkg::req_t                    req,
    output logic [spbs_pkg::PIXEL_W-1:0]      pixel_out
);
    import spbs_pkg::*;

    typedef struct packed {
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
    } rgb_t;

    function automatic rgb_t unpack_split(input logic [15:0] px);
        rgb_t c;
        c.r = {px[15:13], px[5], px[2]};
        c.g = {px[12:10], px[7], px[4], px[1]};
        c.b = {px[9:8], px[6], px[3], px[0]};
        return c;
    endfunction

    function automatic logic [15:0] pack_split(input rgb_t c);
        return {c.r[4:2], c.g[5:3], c.b[4:3],
                c.g[2], c.b[2], c.r[1], c.g[1], c.b[1], c.r[0], c.g[0], c.b[0]};
    endfunction

    logic [2:0] r1, g1, r2, g2;
    logic [1:0] b1, b2;

    logic [7:0] add_res, mod_res;
    logic [3:0] add_r, add_g;
    logic [2:0] add_b;
    logic [5:0] mul_r, mul_g;
    logic [3:0] mul_b;
    logic [6:0] mod_r7, mod_g7;

    rgb_t       lt_src, lt_res, bl_src, bl_res;
    logic [10:0] lt_r, lt_b;
    logic [10:0] lt_g;

    logic [2:0] wa, wp;
    logic [6:0] bl_r, bl_g, bl_b;
    logic [5:0] col_r, col_g, col_b;

    always_comb begin
        r1 = req.first_color[7:5];
        g1 = req.first_color[4:2];
        b1 = req.first_color[1:0];
        r2 = req.second_color[7:5];
        g2 = req.second_color[4:2];
        b2 = req.second_color[1:0];

        // saturating add
        add_r = {1'b0, r1} + {1'b0, r2};
        add_g = {1'b0, g1} + {1'b0, g2};
        add_b = {1'b0, b1} + {1'b0, b2};
        add_res = {(add_r[3] ? 3'd7 : add_r[2:0]),
                   (add_g[3] ? 3'd7 : add_g[2:0]),
                   (add_b[2] ? 2'd3 : add_b[1:0])};

        // modulate
        mul_r = 6'(r1) * 6'(r2);
        mul_g = 6'(g1) * 6'(g2);
        mul_b = 4'(b1) * 4'(b2);
        mod_r7 = div7(9'(mul_r));
        mod_g7 = div7(9'(mul_g));
        mod_res = {mod_r7[2:0], mod_g7[2:0], div3(mul_b)};

        // light: drop the three lowest source bits, scale by level/32
        lt_src = unpack_split(req.pixel_in & 16'hfff8);
        lt_r = 11'(lt_src.r) * 11'(req.light_level);
        lt_g = 11'(lt_src.g) * 11'(req.light_level);
        lt_b = 11'(lt_src.b) * 11'(req.light_level);
        lt_res.r = lt_r[9:5];
        lt_res.g = lt_g[10:5];
        lt_res.b = lt_b[9:5];

        // blend: force bits 5..3 high and 2..0 low, weight (step+2)/7 with step capped at 2
        wa = (req.alpha_step == 2'd3) ? 3'd4 : (3'(req.alpha_step) + 3'd2);
        wp = 3'd7 - wa;
        bl_src = unpack_split((req.pixel_in & 16'hffc0) | 16'h0038);
        col_r = {1'b0, r2, 2'b00} | 6'd4;
        col_g = {g2, 3'b011};
        col_b = {1'b0, b2, 3'b011};
        bl_r = div7(9'(bl_src.r) * 9'(wp)) + div7(9'(col_r) * 9'(wa));
        bl_g = div7(9'(bl_src.g) * 9'(wp)) + div7(9'(col_g) * 9'(wa));
        bl_b = div7(9'(bl_src.b) * 9'(wp)) + div7(9'(col_b) * 9'(wa));
        bl_res.r = (bl_r > 7'd31) ? 5'd31 : bl_r[4:0];
        bl_res.g = (bl_g > 7'd63) ? 6'd63 : bl_g[5:0];
        bl_res.b = (bl_b > 7'd31) ? 5'd31 : bl_b[4:0];

        case (req.req_type)
            OP_ADD:   pixel_out = {8'h00, add_res};
            OP_MOD:   pixel_out = {8'h00, mod_res};
            OP_LIGHT: pixel_out = pack_split(lt_res);
            OP_BLEND: pixel_out = pack_split(bl_res) & 16'hffc0;
            default:  pixel_out = '0;
        endcase
    end

endmodule

[hw/rtl/split_pixel_blend_shade_unit.sv]
// Top level of the split pixel unit: input register, datapath, result register.
// An accepted item passes the input register and then the result register to m_valid.
// Throughput: one item per cycle while m_ready is high; the datapath is one pass.
// The input stage can fill while the result stage stalls; s_ready drops only when
// both stages are full and the result side stalls.
// Reset (aresetn, synchronous, active low) clears both stage valid flags.
module split_pixel_blend_shade_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [spbs_pkg::PIXEL_W-1:0]  s_pixel_in,
    input  logic [spbs_pkg::COLOR_W-1:0]  s_first_color,
    input  logic [spbs_pkg::COLOR_W-1:0]  s_second_color,
    input  logic [spbs_pkg::LEVEL_W-1:0]  s_light_level,
    input  logic [spbs_pkg::STEP_W-1:0]   s_alpha_step,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spbs_pkg::PIXEL_W-1:0]  m_pixel_out
);
    import spbs_pkg::*;

    // input stage
    req_t               req_reg;
    logic               req_valid_reg;
    // result stage
    logic [PIXEL_W-1:0] res_reg;
    logic               res_valid_reg;

    logic [PIXEL_W-1:0] res_next;
    logic               res_advance;
    logic               req_advance;

    // The result register takes a new item when empty or when its item leaves.
    assign res_advance = !res_valid_reg || m_ready;
    // The input register takes a new item when empty or when its item moves on.
    assign req_advance = !req_valid_reg || res_advance;
    assign s_ready     = req_advance;

    spbs_calc u_calc (
        .req       (req_reg),
        .pixel_out (res_next)
    );

    // hold payload while stalled; load on advance
    always_ff @(posedge aclk) begin
        if (req_advance && s_valid) begin
            req_reg.req_type     <= op_t'(s_req_type);
            req_reg.pixel_in     <= s_pixel_in;
            req_reg.first_color  <= s_first_color;
            req_reg.second_color <= s_second_color;
            req_reg.light_level  <= s_light_level;
            req_reg.alpha_step   <= s_alpha_step;
        end
        if (res_advance && req_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (req_advance) begin
                req_valid_reg <= s_valid;
            end
            if (res_advance) begin
                res_valid_reg <= req_valid_reg;
            end
        end
    end

    assign m_valid     = res_valid_reg;
    assign m_pixel_out = res_reg;

    // An accepted item always lands in the input stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> req_valid_reg)
        else $error("accepted item lost before input stage");

    // An item in the input stage moves to the result stage when that stage frees up.
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && res_advance) |=> m_valid)
        else $error("item lost between input and result stage");

    // Both stages full and the result stalled: no new item may enter.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full");

    // A stalled result stage holds its item and the waiting item in front of it.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && m_valid && !m_ready) |=> (req_valid_reg && m_valid))
        else $error("item dropped during stall");

endmodule
